[sv/nsc_pkg.sv]
// Shared constants, result record and helper functions for the sentence checker.
// No dependencies; imported by the parser, the result register and the top level.
`default_nettype none
package nsc_pkg;

    localparam int NSC_MAX_LINE = 1024;

    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_CR     = 8'h0D;

    localparam logic [23:0] C_NAME_ENC = 24'h454E43;
    localparam logic [23:0] C_NAME_BAT = 24'h424154;
    localparam logic [23:0] C_NAME_STS = 24'h535453;
    localparam logic [23:0] C_NAME_ACK = 24'h41434B;
    localparam logic [23:0] C_NAME_ERR = 24'h455252;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_DOLLAR = 3'd1;
    localparam logic [2:0] ST_NO_BODY   = 3'd2;
    localparam logic [2:0] ST_BAD_DIGIT = 3'd3;
    localparam logic [2:0] ST_MISMATCH  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW  = 3'd5;

    localparam logic [2:0] CMD_ENC   = 3'd0;
    localparam logic [2:0] CMD_BAT   = 3'd1;
    localparam logic [2:0] CMD_STS   = 3'd2;
    localparam logic [2:0] CMD_ACK   = 3'd3;
    localparam logic [2:0] CMD_ERR   = 3'd4;
    localparam logic [2:0] CMD_OTHER = 3'd5;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [2:0]  command;
        logic [7:0]  received_sum;
        logic [7:0]  computed_sum;
        logic [10:0] payload_length;
    } t_result;

    // Bit 4 flags a byte that is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) v = {1'b0, 4'(b - 8'h30)};
        else if (b >= 8'h41 && b <= 8'h46) v = {1'b0, 4'(b - 8'h37)};
        else if (b >= 8'h61 && b <= 8'h66) v = {1'b0, 4'(b - 8'h57)};
        return v;
    endfunction

    function automatic logic [2:0] command_code(input logic [23:0] letters,
                                                input logic [2:0] len);
        logic [2:0] c;
        c = CMD_OTHER;
        if (len == 3'd3) begin
            case (letters)
                C_NAME_ENC: c = CMD_ENC;
                C_NAME_BAT: c = CMD_BAT;
                C_NAME_STS: c = CMD_STS;
                C_NAME_ACK: c = CMD_ACK;
                C_NAME_ERR: c = CMD_ERR;
                default:    c = CMD_OTHER;
            endcase
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[sv/nsc_line_parser.sv]
// Per-line state and next-state logic: phase, running XOR, command letters and counts.
// Depends on nsc_pkg for character codes, status codes and the result record.
`default_nettype none
module nsc_line_parser
    import nsc_pkg::*;
#(
    parameter int MAX_LINE = NSC_MAX_LINE
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    output logic            o_has_result,
    output t_result         o_result
);
    localparam int LW = $clog2(MAX_LINE + 1);

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_CR    = 3'd1;
    localparam logic [2:0] PH_SKIP  = 3'd2;
    localparam logic [2:0] PH_CMD   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_DIG1  = 3'd5;
    localparam logic [2:0] PH_DIG2  = 3'd6;
    localparam logic [2:0] PH_TAIL  = 3'd7;

    logic [2:0]    r_phase,      n_phase;
    logic [LW-1:0] r_line_count, n_line_count;
    logic [7:0]    r_xor_sum,    n_xor_sum;
    logic [23:0]   r_letters,    n_letters;
    logic [2:0]    r_cmd_len,    n_cmd_len;
    logic          r_body_seen,  n_body_seen;
    logic [LW-1:0] r_data_count, n_data_count;
    logic [7:0]    r_digits,     n_digits;
    logic          r_fault,      n_fault;

    logic          clear;
    logic [2:0]    status;
    logic [4:0]    hex;
    logic [LW+10:0] count_wide;

    assign hex        = hex_value(i_byte);
    assign count_wide = {11'b0, r_data_count};

    always_comb begin
        n_phase      = r_phase;
        n_line_count = r_line_count;
        n_xor_sum    = r_xor_sum;
        n_letters    = r_letters;
        n_cmd_len    = r_cmd_len;
        n_body_seen  = r_body_seen;
        n_data_count = r_data_count;
        n_digits     = r_digits;
        n_fault      = r_fault;
        clear        = 1'b0;
        status       = ST_OK;
        o_has_result = 1'b0;
        o_result     = '0;

        if (i_byte == C_LF) begin
            clear = 1'b1;
            unique case (r_phase)
                PH_START, PH_CR:  status = ST_OK;
                PH_SKIP:          status = ST_NO_DOLLAR;
                PH_CMD, PH_DATA:  status = ST_NO_BODY;
                PH_DIG1, PH_DIG2: status = r_body_seen ? ST_BAD_DIGIT : ST_NO_BODY;
                default: begin
                    if (!r_body_seen) status = ST_NO_BODY;
                    else if (r_fault) status = ST_BAD_DIGIT;
                    else status = (r_digits == r_xor_sum) ? ST_OK : ST_MISMATCH;
                end
            endcase
            // empty line: drop silently
            o_has_result = !(r_phase == PH_START || r_phase == PH_CR);
        end else if (r_line_count >= LW'(MAX_LINE)) begin
            clear        = 1'b1;
            status       = ST_OVERFLOW;
            o_has_result = 1'b1;
        end else begin
            n_line_count = r_line_count + 1'b1;
            unique case (r_phase)
                PH_START: begin
                    if (i_byte == C_DOLLAR) n_phase = PH_CMD;
                    else if (i_byte == C_CR) n_phase = PH_CR;
                    else n_phase = PH_SKIP;
                end
                PH_CR: n_phase = PH_SKIP;
                PH_CMD: begin
                    if (i_byte == C_STAR) begin
                        n_phase = PH_DIG1;
                    end else begin
                        n_xor_sum   = r_xor_sum ^ i_byte;
                        n_body_seen = 1'b1;
                        if (i_byte == C_COMMA) begin
                            n_phase = PH_DATA;
                        end else if (r_cmd_len < 3'd3) begin
                            n_letters = {r_letters[15:0], i_byte};
                            n_cmd_len = r_cmd_len + 1'b1;
                        end else begin
                            n_cmd_len = 3'd4;
                        end
                    end
                end
                PH_DATA: begin
                    if (i_byte == C_STAR) begin
                        n_phase = PH_DIG1;
                    end else begin
                        n_xor_sum    = r_xor_sum ^ i_byte;
                        n_body_seen  = 1'b1;
                        n_data_count = r_data_count + 1'b1;
                        o_has_result = 1'b1;
                    end
                end
                PH_DIG1: begin
                    if (hex[4]) n_fault = 1'b1;
                    else n_digits = {hex[3:0], 4'h0};
                    n_phase = PH_DIG2;
                end
                PH_DIG2: begin
                    if (hex[4]) n_fault = 1'b1;
                    else n_digits = {r_digits[7:4], hex[3:0]};
                    n_phase = PH_TAIL;
                end
                default: n_phase = r_phase;
            endcase
        end

        if (o_has_result) begin
            if (clear) begin
                o_result.kind           = KIND_VERDICT;
                o_result.status         = status;
                o_result.command        = command_code(r_letters, r_cmd_len);
                o_result.received_sum   = r_digits;
                o_result.computed_sum   = r_xor_sum;
                o_result.payload_length = count_wide[10:0];
            end else begin
                o_result.kind         = KIND_PAYLOAD;
                o_result.payload_byte = i_byte;
            end
        end

        if (clear) begin
            n_phase      = PH_START;
            n_line_count = '0;
            n_xor_sum    = '0;
            n_letters    = '0;
            n_cmd_len    = '0;
            n_body_seen  = 1'b0;
            n_data_count = '0;
            n_digits     = '0;
            n_fault      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_line_count <= '0;
            r_xor_sum    <= '0;
            r_letters    <= '0;
            r_cmd_len    <= '0;
            r_body_seen  <= 1'b0;
            r_data_count <= '0;
            r_digits     <= '0;
            r_fault      <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_line_count <= n_line_count;
            r_xor_sum    <= n_xor_sum;
            r_letters    <= n_letters;
            r_cmd_len    <= n_cmd_len;
            r_body_seen  <= n_body_seen;
            r_data_count <= n_data_count;
            r_digits     <= n_digits;
            r_fault      <= n_fault;
        end
    end

endmodule
`default_nettype wire

[sv/nsc_result_reg.sv]
// Output register holding one result request until the consumer takes it.
// Depends on nsc_pkg for the result record.
`default_nettype none
module nsc_result_reg
    import nsc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_result      o_result
);
    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

[sv/nmea_sentence_checker_unit.sv]
// Sentence checker: input register, line parser, output register.
// Bytes wait in the input register; each result is loaded into the output register.
// Throughput: one byte per cycle while results are taken; set by the single
// parser update between the input and output registers.
// Reset (synchronous, active low) empties both registers and starts a new line.
`default_nettype none
module nmea_sentence_checker_unit
    import nsc_pkg::*;
#(
    parameter int MAX_LINE = NSC_MAX_LINE
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_kind,
    output logic [7:0]       o_payload_byte,
    output logic [2:0]       o_status,
    output logic [2:0]       o_command,
    output logic [7:0]       o_received_sum,
    output logic [7:0]       o_computed_sum,
    output logic [10:0]      o_payload_length
);
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       advance;
    logic       has_result;
    t_result    result;
    t_result    out_result;

    // advance the held byte whenever the output slot is free or draining
    assign advance = r_in_valid && (!o_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    nsc_line_parser #(
        .MAX_LINE(MAX_LINE)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_byte      (r_in_byte),
        .o_has_result(has_result),
        .o_result    (result)
    );

    nsc_result_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && has_result),
        .i_result(result),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_result(out_result)
    );

    assign o_kind           = out_result.kind;
    assign o_payload_byte   = out_result.payload_byte;
    assign o_status         = out_result.status;
    assign o_command        = out_result.command;
    assign o_received_sum   = out_result.received_sum;
    assign o_computed_sum   = out_result.computed_sum;
    assign o_payload_length = out_result.payload_length;

endmodule
`default_nettype wire
